/* design/pscs_pkg.sv */
`timescale 1ns / 1ps

package pscs_pkg;

    localparam int DATA_W          = 32;
    localparam int OUT_IDX_W       = 16;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int INDEX_BITS_DEF  = 16;

    // apb register map, one 32-bit register per word
    localparam int CFG_ADDR_W = 3;
    localparam int REG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_SUM = 1'b0;

    // result flags in m_tuser, lowest bit first
    localparam int USER_FOUND = 0;
    localparam int USER_FULL  = 1;
    localparam int USER_AFTER = 2;
    localparam int USER_W     = 3;

    // control part of the search token that walks down the cell row
    typedef struct packed {
        logic act;  // token carries a live search
        logic hit;  // complement seen in an earlier cell
        logic dup;  // value itself already stored
    } pscs_tok_t;

endpackage

/* design/pair_sum_complement_search_top.sv */
`timescale 1ns / 1ps
// flow: an accepted item loads the head register; the search token then walks the row of
//   TABLE_DEPTH cells one cell per cycle, is judged at the tail and loads the result register
// input: a new item is taken only once the result of the last one is loaded; an item ignored
//   after a found pair skips the row; a result waiting at the output holds the input off
// reset: rst_n clears target_sum, the position counter, fill count, pair flag and all
//   cell valid bits at once; no clearing pass is needed

module pair_sum_complement_search_top #(
    parameter int TABLE_DEPTH = pscs_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = pscs_pkg::INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pscs_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // value
    input  logic [0:0]                          s_tuser,  // start_sequence
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // partner_index, own_index
    output logic [pscs_pkg::USER_W-1:0]         m_tuser   // found, table_full, after_match
);
    import pscs_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [DATA_W-1:0] target_reg;
    logic              cfg_wr;

    pscs_tok_t             tok   [TABLE_DEPTH+1];
    logic [DATA_W-1:0]     key   [TABLE_DEPTH+1];
    logic [DATA_W-1:0]     val   [TABLE_DEPTH+1];
    logic [INDEX_BITS-1:0] pos   [TABLE_DEPTH+1];

    logic                  clear;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [INDEX_BITS-1:0] wr_pos;
    logic [TABLE_DEPTH-1:0] cell_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_TARGET_SUM))
        begin
            target_reg <= pwdata;
        end
    end

    assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TARGET_SUM) ? target_reg : '0;

    assign pos[0] = '0;

    pscs_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_BITS  (INDEX_BITS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .target_sum (target_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_value   (s_tdata),
        .in_start   (s_tuser[0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .clear      (clear),
        .head_tok   (tok[0]),
        .head_key   (key[0]),
        .head_val   (val[0]),
        .tail_tok   (tok[TABLE_DEPTH]),
        .tail_pos   (pos[TABLE_DEPTH]),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_pos     (wr_pos)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign cell_wr[i] = wr_en && (wr_idx == IDX_W'(i));

        pscs_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear),
            .wr_en    (cell_wr[i]),
            .wr_value (val[0]),
            .wr_pos   (wr_pos),
            .in_tok   (tok[i]),
            .in_key   (key[i]),
            .in_val   (val[i]),
            .in_pos   (pos[i]),
            .out_tok  (tok[i+1]),
            .out_key  (key[i+1]),
            .out_val  (val[i+1]),
            .out_pos  (pos[i+1])
        );
    end

    a_one_cell_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_wr))
        else $error("more than one cell written in a cycle");

endmodule

/* design/pscs_cell.sv */
`timescale 1ns / 1ps

module pscs_cell #(
    parameter int INDEX_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        wr_en,
    input  logic [pscs_pkg::DATA_W-1:0] wr_value,
    input  logic [INDEX_BITS-1:0]       wr_pos,
    input  pscs_pkg::pscs_tok_t         in_tok,
    input  logic [pscs_pkg::DATA_W-1:0] in_key,
    input  logic [pscs_pkg::DATA_W-1:0] in_val,
    input  logic [INDEX_BITS-1:0]       in_pos,
    output pscs_pkg::pscs_tok_t         out_tok,
    output logic [pscs_pkg::DATA_W-1:0] out_key,
    output logic [pscs_pkg::DATA_W-1:0] out_val,
    output logic [INDEX_BITS-1:0]       out_pos
);
    import pscs_pkg::*;

    logic                  valid_reg;
    logic [DATA_W-1:0]     value_reg;
    logic [INDEX_BITS-1:0] pos_reg;

    pscs_tok_t             tok_reg;
    pscs_tok_t             tok_next;
    logic [DATA_W-1:0]     key_reg;
    logic [DATA_W-1:0]     val_reg;
    logic [INDEX_BITS-1:0] tpos_reg;
    logic [INDEX_BITS-1:0] tpos_next;

    logic match_key;
    logic match_val;

    assign match_key = valid_reg && (value_reg == in_key);
    assign match_val = valid_reg && (value_reg == in_val);

    always_comb
    begin
        tok_next.act = in_tok.act;
        tok_next.hit = in_tok.hit | match_key;
        tok_next.dup = in_tok.dup | match_val;
        // stored values are unique, the first hit is the only one
        tpos_next    = (match_key && !in_tok.hit) ? pos_reg : in_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_reg <= wr_value;
            pos_reg   <= wr_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= in_key;
        val_reg  <= in_val;
        tpos_reg <= tpos_next;
    end

    assign out_tok = tok_reg;
    assign out_key = key_reg;
    assign out_val = val_reg;
    assign out_pos = tpos_reg;

endmodule

/* design/pscs_ctrl.sv */
`timescale 1ns / 1ps

module pscs_ctrl #(
    parameter int TABLE_DEPTH = 256,
    parameter int INDEX_BITS  = 16,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pscs_pkg::DATA_W-1:0]    target_sum,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pscs_pkg::DATA_W-1:0]    in_value,
    input  logic                           in_start,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*pscs_pkg::OUT_IDX_W-1:0] m_tdata,  // partner_index, own_index
    output logic [pscs_pkg::USER_W-1:0]    m_tuser,   // found, table_full, after_match
    output logic                           clear,
    output pscs_pkg::pscs_tok_t            head_tok,
    output logic [pscs_pkg::DATA_W-1:0]    head_key,
    output logic [pscs_pkg::DATA_W-1:0]    head_val,
    input  pscs_pkg::pscs_tok_t            tail_tok,
    input  logic [INDEX_BITS-1:0]          tail_pos,
    output logic                           wr_en,
    output logic [IDX_W-1:0]               wr_idx,
    output logic [INDEX_BITS-1:0]          wr_pos
);
    import pscs_pkg::*;

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EMIT} state_t;

    state_t                 state_reg, state_next;
    logic [INDEX_BITS-1:0]  pos_reg, pos_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   pair_reg, pair_next;
    pscs_tok_t              head_tok_reg, head_tok_next;
    logic [DATA_W-1:0]      head_key_reg, head_key_next;
    logic [DATA_W-1:0]      head_val_reg, head_val_next;
    logic [OUT_IDX_W-1:0]   res_partner_reg, res_partner_next;
    logic [OUT_IDX_W-1:0]   res_own_reg, res_own_next;
    logic [USER_W-1:0]      res_flags_reg, res_flags_next;
    logic                   m_valid_reg, m_valid_next;
    logic [2*OUT_IDX_W-1:0] m_data_reg, m_data_next;
    logic [USER_W-1:0]      m_user_reg, m_user_next;

    logic accept;
    logic store_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign clear    = accept && in_start;

    // miss, not yet stored, position still free, room in the row
    assign store_ok = !tail_tok.hit && !tail_tok.dup && (pos_reg != POS_MAX)
                      && (fill_reg < FILL_MAX);
    assign wr_en  = (state_reg == ST_SEARCH) && tail_tok.act && store_ok;
    assign wr_idx = fill_reg[IDX_W-1:0];
    assign wr_pos = pos_reg;

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        fill_next        = fill_reg;
        pair_next        = pair_reg;
        head_tok_next    = '0;
        head_key_next    = head_key_reg;
        head_val_next    = head_val_reg;
        res_partner_next = res_partner_reg;
        res_own_next     = res_own_reg;
        res_flags_next   = res_flags_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_start)
                    begin
                        pos_next  = '0;
                        fill_next = '0;
                        pair_next = 1'b0;
                    end
                    if (pair_reg && !in_start)
                    begin
                        res_partner_next       = '0;
                        res_own_next           = OUT_IDX_W'(pos_reg);
                        res_flags_next         = '0;
                        res_flags_next[USER_AFTER] = 1'b1;
                        state_next             = ST_EMIT;
                    end
                    else
                    begin
                        head_tok_next.act = 1'b1;
                        head_key_next     = target_sum - in_value;
                        head_val_next     = in_value;
                        state_next        = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tail_tok.act)
                begin
                    res_partner_next = '0;
                    res_own_next     = OUT_IDX_W'(pos_reg);
                    res_flags_next   = '0;
                    if (tail_tok.hit)
                    begin
                        res_flags_next[USER_FOUND] = 1'b1;
                        res_partner_next           = OUT_IDX_W'(tail_pos);
                        pair_next                  = 1'b1;
                    end
                    else if (pos_reg == POS_MAX)
                    begin
                        res_flags_next[USER_FULL] = 1'b1;
                    end
                    else
                    begin
                        if (!tail_tok.dup)
                        begin
                            if (fill_reg < FILL_MAX)
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                res_flags_next[USER_FULL] = 1'b1;
                            end
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_own_reg, res_partner_reg};
                    m_user_next  = res_flags_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            fill_reg        <= '0;
            pair_reg        <= 1'b0;
            head_tok_reg    <= '0;
            head_key_reg    <= '0;
            head_val_reg    <= '0;
            res_partner_reg <= '0;
            res_own_reg     <= '0;
            res_flags_reg   <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_user_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            fill_reg        <= fill_next;
            pair_reg        <= pair_next;
            head_tok_reg    <= head_tok_next;
            head_key_reg    <= head_key_next;
            head_val_reg    <= head_val_next;
            res_partner_reg <= res_partner_next;
            res_own_reg     <= res_own_next;
            res_flags_reg   <= res_flags_next;
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
            m_user_reg      <= m_user_next;
        end
    end

    assign head_tok = head_tok_reg;
    assign head_key = head_key_reg;
    assign head_val = head_val_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail_tok.act |-> state_reg == ST_SEARCH)
        else $error("search token left the row outside a search");

    a_start_clears_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_start) |=> !pair_reg)
        else $error("pair flag survived a sequence start");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond table depth");

    a_found_excl_after: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_user_reg[USER_FOUND] && m_user_reg[USER_AFTER]))
        else $error("found and after_match set together");

endmodule

/* bench/pscs_search_checker.sv */
`timescale 1ns / 1ps

module pscs_search_checker
    import pscs_pkg::*;
#(
    parameter int TABLE_DEPTH = pscs_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = pscs_pkg::INDEX_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,  // value
    input  logic [0:0]            s_tuser,  // start_sequence
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,  // partner_index, own_index
    input  logic [USER_W-1:0]     m_tuser,  // found, table_full, after_match
    output int                    fail_count,
    output int                    results_owed,
    output int                    items_seen
);

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] partner;
        logic [OUT_IDX_W-1:0] own;
        logic                 full;
        logic                 after;
    } pair_result_t;

    // the all-ones position is reserved, the counter saturates there
    localparam longint unsigned POS_LIMIT = (64'd1 << INDEX_BITS) - 64'd1;

    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] stored_val [TABLE_DEPTH];
    longint unsigned   stored_pos [TABLE_DEPTH];
    bit                stored_ok  [TABLE_DEPTH];
    longint unsigned   next_pos;
    int                used_cells;
    bit                pair_done;
    pair_result_t      pending_results [$];

    function automatic pair_result_t search_pair(input logic [DATA_W-1:0] v, input logic start);
        pair_result_t      r;
        logic [DATA_W-1:0] want;
        int                hit_at;
        int                dup_at;
        r = '0;
        if (start)
        begin
            foreach (stored_ok[i])
                stored_ok[i] = 1'b0;
            next_pos   = 0;
            used_cells = 0;
            pair_done  = 1'b0;
        end
        r.own = next_pos[OUT_IDX_W-1:0];
        if (pair_done)
        begin
            r.after = 1'b1;
        end
        else
        begin
            want   = target - v;
            hit_at = -1;
            dup_at = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (stored_ok[i] && stored_val[i] == want && hit_at < 0)
                    hit_at = i;
                if (stored_ok[i] && stored_val[i] == v && dup_at < 0)
                    dup_at = i;
            end
            if (hit_at >= 0)
            begin
                r.found   = 1'b1;
                r.partner = stored_pos[hit_at][OUT_IDX_W-1:0];
                pair_done = 1'b1;
            end
            else if (next_pos >= POS_LIMIT)
            begin
                r.full = 1'b1;
            end
            else
            begin
                if (dup_at < 0)
                begin
                    if (used_cells < TABLE_DEPTH)
                    begin
                        stored_val[used_cells] = v;
                        stored_pos[used_cells] = next_pos;
                        stored_ok[used_cells]  = 1'b1;
                        used_cells++;
                    end
                    else
                    begin
                        r.full = 1'b1;
                    end
                end
                next_pos++;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pair_result_t exp_r;
        pair_result_t got_r;
        if (!rst_n)
        begin
            target = '0;
            foreach (stored_ok[i])
                stored_ok[i] = 1'b0;
            next_pos     = 0;
            used_cells   = 0;
            pair_done    = 1'b0;
            pending_results.delete();
            fail_count   = 0;
            results_owed = 0;
            items_seen   = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[CFG_ADDR_W-1:2] == REG_TARGET_SUM)
            begin
                if (pwrite)
                    target = pwdata;
                else
                    check_field("target_sum readback", target, prdata);
            end
            if (m_tvalid && m_tready)
            begin
                got_r.found   = m_tuser[USER_FOUND];
                got_r.full    = m_tuser[USER_FULL];
                got_r.after   = m_tuser[USER_AFTER];
                got_r.partner = m_tdata[OUT_IDX_W-1:0];
                got_r.own     = m_tdata[2*OUT_IDX_W-1:OUT_IDX_W];
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: unexpected result, expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("found", exp_r.found, got_r.found);
                    check_field("partner_index", exp_r.partner, got_r.partner);
                    check_field("own_index", exp_r.own, got_r.own);
                    check_field("table_full", exp_r.full, got_r.full);
                    check_field("after_match", exp_r.after, got_r.after);
                end
            end
            if (s_tvalid && s_tready)
            begin
                exp_r = search_pair(s_tdata, s_tuser[0]);
                pending_results = {pending_results, exp_r};
                items_seen++;
            end
            results_owed = pending_results.size();
        end
    end

endmodule

/* bench/tb_pair_sum_complement_search_top.sv */
`timescale 1ns / 1ps

module tb_pair_sum_complement_search_top;
    import pscs_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int PHASE_ITEMS    = 300;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int MAX_GAP        = 13;

    localparam logic [REG_IDX_W-1:0]  REG_NONE    = REG_TARGET_SUM + 1'b1;
    localparam logic [CFG_ADDR_W-1:0] TARGET_ADDR = {REG_TARGET_SUM, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR  = {REG_NONE, 2'b00};

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;  // value
    logic [0:0]            s_tuser  = '0;  // start_sequence
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;        // partner_index, own_index
    logic [USER_W-1:0]     m_tuser;        // found, table_full, after_match

    int          fail_count;
    int          results_owed;
    int          items_seen;
    int          stall_cycles = 0;
    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;
    bit          hold_req     = 1'b0;
    logic [31:0] target_now   = '0;
    logic [31:0] seq_vals [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pair_sum_complement_search_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pscs_search_checker search_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .items_seen   (items_seen)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int rx_gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            rx_gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_gap > 0)
            begin
                m_tready = 1'b0;
                repeat (rx_gap) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == TARGET_ADDR)
            target_now = data;
    endtask

    task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr);
        psel  = 1'b1;
        paddr = addr;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic send_item(input logic [31:0] v, input logic st);
        int tx_gap;
        tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (tx_gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (tx_gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tuser  = st;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value(input logic [31:0] base);
        int          sel;
        logic [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 35 || (seq_vals.size() == 0 && sel < 65))
            v = base + $urandom_range(0, 30) - 32'd15;
        else if (sel < 55)
            v = target_now - seq_vals[$urandom_range(0, seq_vals.size() - 1)];
        else if (sel < 65)
            v = seq_vals[$urandom_range(0, seq_vals.size() - 1)];
        else if (sel < 80)
            v = $urandom;
        else
        begin
            case ($urandom_range(0, 4))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h0000_0000;
                3:       v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0001;
            endcase
        end
        return v;
    endfunction

    // mostly well-formed sequences; some skip the opening start or restart midway
    task automatic send_sequence(input int len, input logic [31:0] base);
        logic        st;
        logic [31:0] v;
        for (int k = 0; k < len; k++)
        begin
            st = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
            if (st)
                seq_vals.delete();
            v = pick_value(base);
            send_item(v, st);
            seq_vals = {seq_vals, v};
        end
    endtask

    initial
    begin
        int          rand_base;
        int          phase_base;
        int          phase;
        int          seq_len;
        logic [31:0] phase_target;
        logic [31:0] base;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        cfg_read(TARGET_ADDR);

        // target at its reset value of zero
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h0000_0005, 1'b0);
        send_item(32'h0000_0005, 1'b0);   // duplicate keeps the earlier position
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);   // complement wraps onto itself
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFB, 1'b1);
        send_item(32'h0000_0005, 1'b0);
        wait_idle();

        // unknown register index is dropped
        cfg_write(SPARE_ADDR, 32'h1234_5678);
        cfg_read(TARGET_ADDR);
        cfg_write(TARGET_ADDR, 32'h7FFF_FFFF);
        cfg_read(TARGET_ADDR);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        wait_idle();
        cfg_write(TARGET_ADDR, 32'h8000_0000);
        cfg_read(TARGET_ADDR);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h8000_0001, 1'b0);
        wait_idle();

        // fill every cell, then overflow, duplicate and hit on a full table
        cfg_write(TARGET_ADDR, 32'h0000_0000);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        for (int i = 1; i <= DEPTH + 4; i++)
            send_item(32'(i), i == 1);
        send_item(32'h0000_0007, 1'b0);
        send_item(32'hFFFF_FFFD, 1'b0);
        send_item(32'h0000_0009, 1'b0);
        wait_idle();
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        rand_base = items_seen;
        phase     = 0;
        while (items_seen - rand_base < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase)
                0:       phase_target = 32'h8000_0000;
                1:       phase_target = 32'h7FFF_FFFF;
                2:       phase_target = 32'hFFFF_FFFF;
                default: phase_target = $urandom;
            endcase
            cfg_write(TARGET_ADDR, phase_target);
            cfg_read(TARGET_ADDR);
            base = $urandom_range(0, 1) ? 32'h0 : 32'($urandom);
            if (phase == 1)
                hold_req = 1'b1;
            phase_base = items_seen;
            while (items_seen - phase_base < PHASE_ITEMS &&
                   items_seen - rand_base < RANDOM_ITEMS)
            begin
                tx_calm = ($urandom_range(0, 7) == 0);
                rx_calm = ($urandom_range(0, 7) == 0);
                seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
                send_sequence(seq_len, base);
            end
            phase++;
        end

        wait_idle();
        repeat (DEPTH + 8) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
